@@ rtl/core/lfuc_pkg.sv @@
// Shared types and constants for the LFU cache table.
// Holds the request and response word layouts and the sequencer states.
// No dependencies.
`timescale 1ns / 1ps

package lfuc_pkg;

  // Request word: kind 0 is a get, kind 1 is a put.
  typedef struct packed {
    logic               kind;
    logic signed [31:0] key;
    logic signed [31:0] value;
  } req_word_t;

  typedef struct packed {
    logic               hit;
    logic signed [31:0] read_value;
    logic               evicted;
    logic signed [31:0] evicted_key;
  } rsp_word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_UPDATE,
    ST_RESULT
  } lfuc_state_t;

  localparam logic        KIND_GET         = 1'b0;
  localparam logic        KIND_PUT         = 1'b1;
  localparam logic        CFG_IDX_CAPACITY = 1'b0;
  localparam logic [4:0]  CAPACITY_RESET   = 5'd16;
  localparam logic [31:0] COUNT_MAX        = 32'hFFFF_FFFF;
  localparam logic [31:0] READ_MISS        = 32'hFFFF_FFFF;

endpackage

@@ rtl/core/lfu_cache_table.sv @@
// Top level of the LFU cache table with oldest-stamp tie break.
// Holds the slot memories, the scan sequencer and the configuration port.
// Depends on lfuc_pkg.
//
//   channel  | handshake                        | payload
//   ---------+----------------------------------+---------------------------
//   req      | req_valid / req_stall            | req_word (kind, key, value)
//   rsp      | rsp_valid / rsp_stall            | rsp_word (hit, read_value,
//            |                                  |   evicted, evicted_key)
//   config   | psel, penable, pwrite, pready    | paddr, pwdata, prdata
//
// An operation scans the N occupied slots (at most ENTRIES) one by one, then
// passes the drain, update and result states back to idle; with no occupied
// slot it goes straight to update, with capacity zero straight to result.
// A new word is taken only in idle. The scan uses the single match and rank
// comparator, which sees one slot per cycle from the registered memory read
// port. Occupied slots always sit at indexes below the fill count, so the slot
// memories need no clearing after reset. Reset is synchronous and active high.
// req_stall is high while an operation is in flight; a finished word waits in
// the response register while the next request is already taken, and while
// that register stays stalled the next result is held in the result state.
`timescale 1ns / 1ps

module lfu_cache_table
  import lfuc_pkg::*;
#(
  parameter int ENTRIES = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  input  req_word_t   req_word,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output rsp_word_t   rsp_word,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int AW    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int OCC_W = $clog2(ENTRIES + 1);
  localparam int CW    = (OCC_W > 5) ? OCC_W : 5;

  // Slot memories
  logic [31:0] slot_key       [ENTRIES];
  logic [31:0] slot_value     [ENTRIES];
  logic [31:0] slot_use_count [ENTRIES];
  logic [63:0] slot_stamp     [ENTRIES];

  lfuc_state_t state, state_next;

  logic [4:0]       capacity;
  logic [CW-1:0]    cap_eff;
  logic             cap_zero;
  logic [OCC_W-1:0] occ;
  logic [63:0]      op_stamp;

  logic             op_kind;
  logic [31:0]      op_key;
  logic [31:0]      op_value;

  logic [OCC_W-1:0] scan_idx;
  logic             cmp_valid;
  logic [AW-1:0]    cmp_idx;
  logic [31:0]      rd_key;
  logic [31:0]      rd_value;
  logic [31:0]      rd_cnt;
  logic [63:0]      rd_stamp;

  logic             found;
  logic [AW-1:0]    found_idx;
  logic [31:0]      found_value;
  logic [31:0]      found_cnt;
  logic             have_victim;
  logic [AW-1:0]    vic_idx;
  logic [31:0]      vic_key;
  logic [31:0]      vic_cnt;
  logic [63:0]      vic_stamp;

  rsp_word_t        res_word;

  logic             accept;
  logic             scan_last;
  logic             out_free;
  logic             rank_below;
  logic             evict;
  logic             insert;
  logic [AW-1:0]    wr_idx;
  logic [31:0]      cnt_inc;
  logic             cfg_write;

  // Configuration port
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == CFG_IDX_CAPACITY);
  assign prdata    = (paddr[2] == CFG_IDX_CAPACITY) ? {27'd0, capacity} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAPACITY_RESET;
    end else if (cfg_write) begin
      capacity <= pwdata[4:0];
    end
  end

  // Capacities above the table size behave as the table size.
  assign cap_eff  = (CW'(capacity) > CW'(ENTRIES)) ? CW'(ENTRIES) : CW'(capacity);
  assign cap_zero = (capacity == 5'd0);

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign scan_last = (scan_idx == occ - OCC_W'(1));
  assign out_free  = !rsp_valid || !rsp_stall;

  always_comb begin
    state_next = state;
    req_stall  = 1'b1;
    accept     = 1'b0;
    case (state)
      ST_IDLE: begin
        req_stall = 1'b0;
        accept    = req_valid;
        if (req_valid) begin
          if (cap_zero) begin
            state_next = ST_RESULT;
          end else if (occ == '0) begin
            state_next = ST_UPDATE;
          end else begin
            state_next = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (scan_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_next = ST_UPDATE;
      end
      ST_UPDATE: begin
        state_next = ST_RESULT;
      end
      ST_RESULT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Operation registers and the global stamp
  always_ff @(posedge clk) begin
    if (accept) begin
      op_kind  <= req_word.kind;
      op_key   <= req_word.key;
      op_value <= req_word.value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      op_stamp <= 64'd0;
    end else if (accept && !cap_zero) begin
      op_stamp <= op_stamp + 64'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_idx  <= '0;
      cmp_valid <= 1'b0;
    end else begin
      cmp_valid <= (state == ST_SCAN);
      if (accept) begin
        scan_idx <= '0;
      end else if (state == ST_SCAN) begin
        scan_idx <= scan_idx + OCC_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    cmp_idx <= scan_idx[AW-1:0];
  end

  // Registered read port, one slot per cycle
  always_ff @(posedge clk) begin
    rd_key   <= slot_key[scan_idx[AW-1:0]];
    rd_value <= slot_value[scan_idx[AW-1:0]];
    rd_cnt   <= slot_use_count[scan_idx[AW-1:0]];
    rd_stamp <= slot_stamp[scan_idx[AW-1:0]];
  end

  // Replacement order: count, then stamp, then signed key. Slots arrive in
  // ascending order, so a strict compare keeps the lowest index on a full tie.
  always_comb begin
    if (!have_victim) begin
      rank_below = 1'b1;
    end else if (rd_cnt != vic_cnt) begin
      rank_below = rd_cnt < vic_cnt;
    end else if (rd_stamp != vic_stamp) begin
      rank_below = rd_stamp < vic_stamp;
    end else begin
      rank_below = $signed(rd_key) < $signed(vic_key);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      found       <= 1'b0;
      have_victim <= 1'b0;
    end else if (accept) begin
      found       <= 1'b0;
      have_victim <= 1'b0;
    end else if (cmp_valid) begin
      if (!found && rd_key == op_key) begin
        found <= 1'b1;
      end
      if (rank_below) begin
        have_victim <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmp_valid && !found && rd_key == op_key) begin
      found_idx   <= cmp_idx;
      found_value <= rd_value;
      found_cnt   <= rd_cnt;
    end
    if (cmp_valid && rank_below) begin
      vic_idx   <= cmp_idx;
      vic_key   <= rd_key;
      vic_cnt   <= rd_cnt;
      vic_stamp <= rd_stamp;
    end
  end

  // Update step
  assign evict   = !found && (op_kind == KIND_PUT) && have_victim
                   && (CW'(occ) >= cap_eff);
  assign insert  = !found && (op_kind == KIND_PUT);
  assign cnt_inc = (found_cnt == COUNT_MAX) ? found_cnt : found_cnt + 32'd1;

  always_comb begin
    if (found) begin
      wr_idx = found_idx;
    end else if (evict) begin
      wr_idx = vic_idx;
    end else begin
      wr_idx = occ[AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_UPDATE) begin
      if (insert) begin
        slot_key[wr_idx] <= op_key;
      end
      if (op_kind == KIND_PUT) begin
        slot_value[wr_idx] <= op_value;
      end
      if (found || insert) begin
        slot_use_count[wr_idx] <= found ? cnt_inc : 32'd1;
        slot_stamp[wr_idx]     <= op_stamp;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= '0;
    end else if (state == ST_UPDATE && insert && !evict) begin
      occ <= occ + OCC_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (accept && cap_zero) begin
      res_word.hit         <= 1'b0;
      res_word.read_value  <= READ_MISS;
      res_word.evicted     <= 1'b0;
      res_word.evicted_key <= 32'd0;
    end else if (state == ST_UPDATE) begin
      res_word.hit         <= found;
      res_word.read_value  <= (found && op_kind == KIND_GET) ? found_value : READ_MISS;
      res_word.evicted     <= evict;
      res_word.evicted_key <= evict ? vic_key : 32'd0;
    end
  end

  // Response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (state == ST_RESULT && out_free) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_RESULT && out_free) begin
      rsp_word <= res_word;
    end
  end

  // Checks
  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    CW'(occ) <= CW'(ENTRIES))
    else $error("occupancy beyond table size");

  a_hit_no_evict: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !(rsp_word.hit && rsp_word.evicted))
    else $error("hit and eviction in one word");

  a_zero_cap_stamp: assert property (@(posedge clk) disable iff (rst)
    (accept && cap_zero) |=> $stable(op_stamp))
    else $error("stamp advanced with capacity zero");

  a_occ_step: assert property (@(posedge clk) disable iff (rst)
    !$stable(occ) |-> (occ == $past(occ) + OCC_W'(1)) && $past(state == ST_UPDATE))
    else $error("occupancy moved outside an insert");

endmodule
